FILE: src/spq_pkg.sv
// Shared types, codes and helpers for the stable priority queue.
package spq_pkg;

   // Width of a stored priority and its legal range.
   localparam int PRI_BITS = 3;
   localparam logic [PRI_BITS-1:0] MAX_PRIORITY = 3'd5;
   localparam logic [PRI_BITS-1:0] MIN_PRIORITY = 3'd1;

   // Request modes.
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Operation that every cell of the row performs.
   typedef enum logic [1:0] {
      OP_HOLD = 2'd0,
      OP_PUSH = 2'd1,
      OP_POP  = 2'd2
   } op_type;

   // Command broadcast from the controller to all cells.
   typedef struct packed {
      op_type              op;
      logic [PRI_BITS-1:0] priority_val;
   } cell_cmd_type;

   // Saturate a pushed priority into the legal range.
   function automatic logic [PRI_BITS-1:0] clamp_priority(input logic [PRI_BITS-1:0] p);
      logic [PRI_BITS-1:0] r;
      r = p;
      if (p < MIN_PRIORITY) r = MIN_PRIORITY;
      else if (p > MAX_PRIORITY) r = MAX_PRIORITY;
      return r;
   endfunction

endpackage

FILE: src/spq_cell.sv
// One cell of the sorted row: holds one entry and trades it with its neighbors.
module spq_cell
   import spq_pkg::*;
#(
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  cell_cmd_type          cmd,
   input  logic [VALUE_BITS-1:0] new_value,
   input  logic                  occupied,
   input  logic                  left_keep,
   input  logic [VALUE_BITS-1:0] left_value,
   input  logic [PRI_BITS-1:0]   left_priority,
   input  logic [VALUE_BITS-1:0] right_value,
   input  logic [PRI_BITS-1:0]   right_priority,
   output logic                  keep,
   output logic [VALUE_BITS-1:0] value,
   output logic [PRI_BITS-1:0]   priority_val
);

   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [PRI_BITS-1:0]   priority_ff, priority_in;

   // An occupied cell whose priority is equal or higher stays in place on a push.
   assign keep = occupied && (priority_ff >= cmd.priority_val);

   // Next entry: hold, take the new entry, shift right on push, or shift left on pop.
   always_comb begin
      value_in    = value_ff;
      priority_in = priority_ff;
      case (cmd.op)
         OP_PUSH: begin
            if (!keep) begin
               if (left_keep) begin
                  value_in    = new_value;
                  priority_in = cmd.priority_val;
               end else begin
                  value_in    = left_value;
                  priority_in = left_priority;
               end
            end
         end
         OP_POP: begin
            value_in    = right_value;
            priority_in = right_priority;
         end
         default: begin
            value_in    = value_ff;
            priority_in = priority_ff;
         end
      endcase
   end

   // Entry storage needs no reset; occupancy comes from the controller's count.
   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      priority_ff <= priority_in;
   end

   assign value        = value_ff;
   assign priority_val = priority_ff;

endmodule

FILE: src/stable_priority_queue_top.sv
// Top level of the stable priority queue: controller, row of cells and response register.
//
// A sorted row of CAPACITY cells keeps entries in falling priority, equal
// priorities in arrival order. A push compares the new priority against
// all cells at once and each cell either holds, takes the new entry, or
// takes its left neighbor's entry; a pop shifts every cell left by one and
// returns the old head. A new request is taken in every cycle in which the
// response register is empty or being drained, so the sustained rate is one
// request per cycle. Each request gives one response: status, the popped entry
// (zero when nothing was removed) and the occupancy after the request. A push
// to a full queue and a pop from an empty one leave the contents unchanged.
module stable_priority_queue_top
   import spq_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 16,
   localparam int CNT_BITS  = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [VALUE_BITS-1:0] req_item_value,
   input  logic [PRI_BITS-1:0]   req_item_priority,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [VALUE_BITS-1:0] rsp_popped_value,
   output logic [PRI_BITS-1:0]   rsp_popped_priority,
   output logic [CNT_BITS-1:0]   rsp_occupancy
);

   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(CAPACITY);

   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic [VALUE_BITS-1:0] pvalue_ff, pvalue_in;
   logic [PRI_BITS-1:0]   ppri_ff, ppri_in;
   logic [CNT_BITS-1:0]   occ_ff;

   logic accept, is_full, is_empty, do_push, do_pop;
   cell_cmd_type cmd;

   logic [VALUE_BITS-1:0] cell_value [CAPACITY];
   logic [PRI_BITS-1:0]   cell_pri   [CAPACITY];
   logic                  cell_keep  [CAPACITY];

   // Request handshake: stall only while a response waits and is itself stalled.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff == FULL_COUNT);
   assign is_empty  = (count_ff == '0);
   assign do_push   = accept && (req_mode == MODE_PUSH) && !is_full;
   assign do_pop    = accept && (req_mode == MODE_POP) && !is_empty;

   // Command broadcast to the row.
   always_comb begin
      cmd.priority_val = clamp_priority(req_item_priority);
      if (do_push) cmd.op = OP_PUSH;
      else if (do_pop) cmd.op = OP_POP;
      else cmd.op = OP_HOLD;
   end

   // Row of cells; the head is cell zero.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                  left_keep;
      logic [VALUE_BITS-1:0] left_value, right_value;
      logic [PRI_BITS-1:0]   left_pri, right_pri;

      if (i == 0) begin : g_head
         assign left_keep  = 1'b1;
         assign left_value = cell_value[i];
         assign left_pri   = cell_pri[i];
      end else begin : g_inner
         assign left_keep  = cell_keep[i-1];
         assign left_value = cell_value[i-1];
         assign left_pri   = cell_pri[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_value = cell_value[i];
         assign right_pri   = cell_pri[i];
      end else begin : g_body
         assign right_value = cell_value[i+1];
         assign right_pri   = cell_pri[i+1];
      end

      spq_cell #(
         .VALUE_BITS(VALUE_BITS)
      ) u_cell (
         .clock         (clock),
         .cmd           (cmd),
         .new_value     (req_item_value),
         .occupied      (CNT_BITS'(i) < count_ff),
         .left_keep     (left_keep),
         .left_value    (left_value),
         .left_priority (left_pri),
         .right_value   (right_value),
         .right_priority(right_pri),
         .keep          (cell_keep[i]),
         .value         (cell_value[i]),
         .priority_val  (cell_pri[i])
      );
   end

   // Entry count and response contents.
   always_comb begin
      count_in = count_ff;
      if (do_push) count_in = count_ff + 1'b1;
      else if (do_pop) count_in = count_ff - 1'b1;

      status_in = STATUS_OK;
      if (req_mode == MODE_POP && is_empty) status_in = STATUS_EMPTY;
      else if (req_mode == MODE_PUSH && is_full) status_in = STATUS_FULL;

      pvalue_in = do_pop ? cell_value[0] : '0;
      ppri_in   = do_pop ? cell_pri[0] : '0;

      rsp_valid_in = rsp_valid_ff;
      if (accept) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload, loaded when a request is taken.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         pvalue_ff <= pvalue_in;
         ppri_ff   <= ppri_in;
         occ_ff    <= count_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_popped_value    = pvalue_ff;
   assign rsp_popped_priority = ppri_ff;
   assign rsp_occupancy       = occ_ff;

endmodule

FILE: src/spq_checker.sv
// Port-level checks for the stable priority queue, bound to the top level.
module spq_checker
   import spq_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 16,
   localparam int CNT_BITS  = $clog2(CAPACITY + 1)
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  req_mode,
   input logic [VALUE_BITS-1:0] req_item_value,
   input logic [PRI_BITS-1:0]   req_item_priority,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [1:0]            rsp_status,
   input logic [VALUE_BITS-1:0] rsp_popped_value,
   input logic [PRI_BITS-1:0]   rsp_popped_priority,
   input logic [CNT_BITS-1:0]   rsp_occupancy
);

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_popped_value) && $stable(rsp_occupancy))
      else $error("stalled response changed");

   // Every taken request shows up as a response in the next cycle.
   a_req_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("taken request gave no response");

   // A pop on an empty queue reports an empty queue and nothing removed.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |->
         rsp_occupancy == '0 && rsp_popped_value == '0 && rsp_popped_priority == '0)
      else $error("empty status with wrong contents");

   // A rejected push only happens on a full queue.
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |->
         rsp_occupancy == CNT_BITS'(CAPACITY) && rsp_popped_priority == '0)
      else $error("full status with wrong occupancy");

   // A removed entry always carries a legal priority and an ok status.
   a_popped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_popped_priority != '0 |->
         rsp_status == STATUS_OK && rsp_popped_priority <= MAX_PRIORITY
         && rsp_occupancy != CNT_BITS'(CAPACITY))
      else $error("popped entry with bad priority or status");

endmodule

bind stable_priority_queue_top spq_checker #(
   .CAPACITY  (CAPACITY),
   .VALUE_BITS(VALUE_BITS)
) u_spq_checker (.*);

FILE: sim/spq_checker.sv
`timescale 1ns / 1ps
// Checker that predicts and compares every response of the stable priority queue.
module spq_scoreboard
   import spq_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 16,
   parameter int CNT_BITS   = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_mode,
   input  logic [VALUE_BITS-1:0] req_item_value,
   input  logic [PRI_BITS-1:0]   req_item_priority,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [1:0]            rsp_status,
   input  logic [VALUE_BITS-1:0] rsp_popped_value,
   input  logic [PRI_BITS-1:0]   rsp_popped_priority,
   input  logic [CNT_BITS-1:0]   rsp_occupancy,
   output int                    fail_count,
   output int                    pending,
   output int                    popped_count,
   output int                    empty_count,
   output int                    full_count
);

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [PRI_BITS-1:0]   prio;
   } queue_entry_type;

   typedef struct packed {
      status_type            status;
      logic [VALUE_BITS-1:0] value;
      logic [PRI_BITS-1:0]   prio;
      logic [CNT_BITS-1:0]   occupancy;
   } response_type;

   // Shadow copy of the queue contents, index 0 is the head.
   queue_entry_type stored_entries[$];
   // Responses still owed by the block, oldest first.
   response_type    expected_responses[$];
   response_type    want;

   // Apply one request to the shadow queue and return the response it must produce.
   function automatic response_type apply_request(input logic mode,
                                                  input logic [VALUE_BITS-1:0] value,
                                                  input logic [PRI_BITS-1:0] prio);
      response_type    r;
      queue_entry_type e;
      int              pos;
      r.status = STATUS_OK;
      r.value = '0;
      r.prio = '0;
      if (mode == MODE_PUSH) begin
         if (stored_entries.size() >= CAPACITY) begin
            r.status = STATUS_FULL;
            full_count++;
         end else begin
            // Out-of-range priorities saturate into the legal range.
            e.value = value;
            if (prio < MIN_PRIORITY) e.prio = MIN_PRIORITY;
            else if (prio > MAX_PRIORITY) e.prio = MAX_PRIORITY;
            else e.prio = prio;
            // The new entry goes behind every entry of equal or higher priority.
            pos = 0;
            while (pos < stored_entries.size() && stored_entries[pos].prio >= e.prio) pos++;
            stored_entries.insert(pos, e);
         end
      end else if (stored_entries.size() == 0) begin
         r.status = STATUS_EMPTY;
         empty_count++;
      end else begin
         e = stored_entries.pop_front();
         r.value = e.value;
         r.prio = e.prio;
         popped_count++;
      end
      r.occupancy = CNT_BITS'(stored_entries.size());
      return r;
   endfunction

   // Check each accepted response first, then predict for the accepted request.
   always @(posedge clock) begin
      if (reset) begin
         stored_entries.delete();
         expected_responses.delete();
         fail_count = 0;
         popped_count = 0;
         empty_count = 0;
         full_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               $display("%0t: response with no request outstanding: status %0d value %h",
                        $time, rsp_status, rsp_popped_value);
               fail_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_popped_value !== want.value) begin
                  $display("%0t: popped_value expected %h actual %h",
                           $time, want.value, rsp_popped_value);
                  fail_count++;
               end
               if (rsp_popped_priority !== want.prio) begin
                  $display("%0t: popped_priority expected %0d actual %0d",
                           $time, want.prio, rsp_popped_priority);
                  fail_count++;
               end
               if (rsp_occupancy !== want.occupancy) begin
                  $display("%0t: occupancy expected %0d actual %0d",
                           $time, want.occupancy, rsp_occupancy);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_responses.push_back(apply_request(req_mode, req_item_value,
                                                       req_item_priority));
         end
      end
      pending = expected_responses.size();
   end

endmodule

FILE: sim/stable_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the stable priority queue: clock, reset, request stimulus and verdict.
module stable_priority_queue_top_tb;
   import spq_pkg::*;

   localparam int CAPACITY        = 16;
   localparam int VALUE_BITS      = 16;
   localparam int CNT_BITS        = $clog2(CAPACITY + 1);
   localparam int RANDOM_REQUESTS = 1380;
   localparam int WATCHDOG_LIMIT  = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_mode = MODE_PUSH;
   logic [VALUE_BITS-1:0] req_item_value = '0;
   logic [PRI_BITS-1:0]   req_item_priority = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_status;
   logic [VALUE_BITS-1:0] rsp_popped_value;
   logic [PRI_BITS-1:0]   rsp_popped_priority;
   logic [CNT_BITS-1:0]   rsp_occupancy;

   int fail_count;
   int pending;
   int popped_count;
   int empty_count;
   int full_count;
   int request_count = 0;
   int stall_cycles = 0;
   bit quiet = 1'b0;
   int push_pct = 50;

   always #5 clock = ~clock;

   stable_priority_queue_top #(
      .CAPACITY(CAPACITY),
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_item_value(req_item_value),
      .req_item_priority(req_item_priority),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_popped_value(rsp_popped_value),
      .rsp_popped_priority(rsp_popped_priority),
      .rsp_occupancy(rsp_occupancy)
   );

   spq_scoreboard #(
      .CAPACITY(CAPACITY),
      .VALUE_BITS(VALUE_BITS)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_item_value(req_item_value),
      .req_item_priority(req_item_priority),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_popped_value(rsp_popped_value),
      .rsp_popped_priority(rsp_popped_priority),
      .rsp_occupancy(rsp_occupancy),
      .fail_count(fail_count),
      .pending(pending),
      .popped_count(popped_count),
      .empty_count(empty_count),
      .full_count(full_count)
   );

   // Response side stalls with a chance of 16 in 100 each cycle, except in the quiet stretch.
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 16);
   end

   // Watchdog: end the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no request or response accepted for %0d cycles",
                  $time, WATCHDOG_LIMIT);
         $display("stable_priority_queue_top_tb failed");
         $finish;
      end
   end

   // Offer one request, possibly after a short idle gap, and hold it until accepted.
   task automatic send_request(input logic mode, input logic [VALUE_BITS-1:0] value,
                               input logic [PRI_BITS-1:0] prio);
      int gap;
      gap = (!quiet && $urandom_range(99) < 8) ? $urandom_range(1, 4) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_item_value <= value;
      req_item_priority <= prio;
      do @(posedge clock); while (req_stall);
      request_count++;
   endtask

   initial begin
      int i;
      logic [VALUE_BITS-1:0] value;
      logic [PRI_BITS-1:0]   prio;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // A pop on the empty queue must report empty and change nothing.
      send_request(MODE_POP, '1, '1);
      // Every priority code, in and out of range, with extreme values.
      for (i = 0; i < 8; i++) begin
         send_request(MODE_PUSH, i[0] ? '1 : '0, i[PRI_BITS-1:0]);
      end
      // Fill the queue with equal priorities to check arrival order among them.
      for (i = 0; i < 8; i++) begin
         send_request(MODE_PUSH, VALUE_BITS'(16'h1000 + i), 3'd3);
      end
      // The queue is now full, so this push must be rejected.
      send_request(MODE_PUSH, 16'hBEEF, MAX_PRIORITY);
      repeat (5) send_request(MODE_POP, VALUE_BITS'($urandom), PRI_BITS'($urandom));

      // Random part: phases lean toward pushes or pops so the queue swings between full and empty.
      for (i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i % 100 == 0) push_pct = 25 + 25 * $urandom_range(2);
         quiet = (i >= 600 && i < 800);
         case ($urandom_range(9))
            0: value = '0;
            1: value = '1;
            default: value = VALUE_BITS'($urandom);
         endcase
         prio = ($urandom_range(9) == 0) ? PRI_BITS'($urandom_range(7))
                                         : PRI_BITS'($urandom_range(1, 5));
         if ($urandom_range(99) < push_pct) begin
            send_request(MODE_PUSH, value, prio);
         end else begin
            send_request(MODE_POP, value, prio);
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // Drain the outstanding responses and keep watching for strays afterwards.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d requests; %0d pops returned an entry.", request_count, popped_count);
      $display("Pops on an empty queue: %0d, pushes refused on a full queue: %0d.",
               empty_count, full_count);
      if (fail_count == 0 && pending == 0) begin
         $display("stable_priority_queue_top_tb passed");
      end else begin
         $display("stable_priority_queue_top_tb failed");
      end
      $finish;
   end

endmodule
